// ===== rtl/pca_pkg.sv =====
// Shared types, codes and arithmetic helpers of the polarization cross-product accumulator.
// Used by pca_ctrl, pca_datapath and pol_cross_product_accumulator_top. No dependencies.
package pca_pkg;

   localparam int ACT_W    = 3;
   localparam int STAT_W   = 2;
   localparam int COORD_W  = 4;
   localparam int POL_W    = 2;
   localparam int IN_W     = 24;
   localparam int ACC_W    = 32;
   localparam int NPOL_W   = 3;
   localparam int NPOL_RST = 4;

   localparam int REQ_TDATA_W = 112;
   localparam int RSP_TDATA_W = 136;

   localparam logic [ACT_W-1:0] ACT_ADD_BOTH  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_ADD_MODEL = 3'd1;
   localparam logic [ACT_W-1:0] ACT_ADD_MEAS  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_READ      = 3'd3;
   localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_BAD_POL = 2'd1;
   localparam logic [STAT_W-1:0] ST_ORDER   = 2'd2;

   typedef struct packed {
      logic latch;
      logic rd_en;
      logic commit;
      logic clr_step;
   } pca_cmd_type;

   typedef struct packed {
      logic out_free;
      logic clr_last;
   } pca_stat_type;

   // hi*(hi-1)/2 for the cross-hand slot offset
   function automatic logic [2:0] tri_offset(input logic [POL_W-1:0] hi);
      logic [2:0] r;
      case (hi)
         2'd2:    r = 3'd1;
         2'd3:    r = 3'd3;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [IN_W-1:0] b);
      logic [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {{(ACC_W+1-IN_W){b[IN_W-1]}}, b};
      if (s[ACC_W] != s[ACC_W-1])
         return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      return s[ACC_W-1:0];
   endfunction

   function automatic logic [ACC_W-1:0] neg_sat(input logic [ACC_W-1:0] a);
      if (a == {1'b1, {(ACC_W-1){1'b0}}})
         return {1'b0, {(ACC_W-1){1'b1}}};
      return ACC_W'(-a);
   endfunction

endpackage

// ===== rtl/pca_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module pca_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [WIDTH-1:0]     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pca_ctrl.sv =====
// Controller of the accumulator: accept, read, write-back/result and clearing sweep.
// Depends on pca_pkg.
module pca_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_is_clear,
   output logic                  req_tready,
   input  pca_pkg::pca_stat_type stat,
   output pca_pkg::pca_cmd_type  cmd
);
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_WRITE = 2'd2;
   localparam logic [1:0] S_CLEAR = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       reply_ff, reply_in;

   always_comb begin
      state_in   = state_ff;
      reply_in   = reply_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               if (req_is_clear) begin
                  state_in = S_CLEAR;
                  reply_in = 1'b1;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_WRITE;
         end
         S_WRITE: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = reply_ff ? S_WRITE : S_IDLE;
               reply_in = 1'b0;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         reply_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         reply_ff <= reply_in;
      end
   end

endmodule

// ===== rtl/pca_datapath.sv =====
// Datapath: item and npol registers, slot addressing, both accumulator RAMs,
// saturating update and the result register. Depends on pca_pkg and pca_ram.
module pca_datapath #(
   parameter int MAX_POL = 4,
   parameter int X_SIZE  = 16,
   parameter int Y_SIZE  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pca_pkg::pca_cmd_type              cmd,
   output pca_pkg::pca_stat_type             stat,
   input  logic [pca_pkg::ACT_W-1:0]         req_tuser,
   input  logic [pca_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                              csr_wr_en,
   input  logic [pca_pkg::NPOL_W-1:0]        csr_wr_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pca_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   localparam int MODEL_SLOTS = MAX_POL * (MAX_POL + 1) / 2;
   localparam int MEAS_SLOTS  = MAX_POL * MAX_POL;
   localparam int CELLS       = X_SIZE * Y_SIZE;
   localparam int MODEL_DEPTH = CELLS * MODEL_SLOTS;
   localparam int MEAS_DEPTH  = CELLS * MEAS_SLOTS;
   localparam int MAW = (MODEL_DEPTH > 1) ? $clog2(MODEL_DEPTH) : 1;
   localparam int QAW = (MEAS_DEPTH > 1) ? $clog2(MEAS_DEPTH) : 1;
   localparam int CW  = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int SW  = $clog2(MEAS_SLOTS + 1);
   localparam int NW  = $clog2(MAX_POL + 1);
   localparam int CO  = pca_pkg::COORD_W;
   localparam int PW  = pca_pkg::POL_W;
   localparam int IW  = pca_pkg::IN_W;
   localparam int AW  = pca_pkg::ACC_W;

   function automatic logic [CO-1:0] wrap_coord(input logic [CO-1:0] v, input int size);
      logic [CO-1:0] r;
      r = v;
      for (int q = 1; q < (1 << CO); q++) begin
         if (q * size <= int'(v)) begin
            r = CO'(int'(v) - q * size);
         end
      end
      return r;
   endfunction

   logic [pca_pkg::ACT_W-1:0]  action_ff;
   logic [CO-1:0]              cell_x_ff, cell_y_ff;
   logic [PW-1:0]              pol_a_ff, pol_b_ff;
   logic [IW-1:0]              model_re_ff, model_im_ff, meas_re_ff, meas_im_ff;
   logic [pca_pkg::NPOL_W-1:0] npol_ff;
   logic [QAW-1:0]             clr_cnt_ff, clr_cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [pca_pkg::STAT_W-1:0] status_ff, status_in;
   logic [AW-1:0]              r0_ff, r1_ff, r2_ff, r3_ff;
   logic [AW-1:0]              r0_in, r1_in, r2_in, r3_in;

   logic [NW-1:0]  np;
   logic [PW-1:0]  hi, lo;
   logic [SW-1:0]  mslot, qslot;
   logic [CW-1:0]  cell_idx;
   logic [MAW-1:0] model_addr, model_waddr;
   logic [QAW-1:0] meas_addr, meas_waddr;
   logic           pol_ok, clr_model;
   logic           model_we, meas_we, model_upd, meas_upd;
   logic [2*AW-1:0] model_rd, meas_rd, model_wd, meas_wd;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         action_ff   <= req_tuser;
         cell_x_ff   <= req_tdata[3:0];
         cell_y_ff   <= req_tdata[7:4];
         pol_a_ff    <= req_tdata[9:8];
         pol_b_ff    <= req_tdata[11:10];
         model_re_ff <= req_tdata[35:12];
         model_im_ff <= req_tdata[59:36];
         meas_re_ff  <= req_tdata[83:60];
         meas_im_ff  <= req_tdata[107:84];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         npol_ff <= pca_pkg::NPOL_W'(pca_pkg::NPOL_RST);
      end else if (csr_wr_en) begin
         npol_ff <= csr_wr_data;
      end
   end

   always_comb begin
      np       = (int'(npol_ff) > MAX_POL) ? NW'(MAX_POL) : NW'(npol_ff);
      pol_ok   = (int'(pol_a_ff) < int'(np)) && (int'(pol_b_ff) < int'(np));
      hi       = (pol_a_ff >= pol_b_ff) ? pol_a_ff : pol_b_ff;
      lo       = (pol_a_ff >= pol_b_ff) ? pol_b_ff : pol_a_ff;
      mslot    = (hi == lo) ? SW'(hi)
               : SW'(int'(np) + int'(lo) + int'(pca_pkg::tri_offset(hi)));
      qslot    = SW'(int'(pol_a_ff) + int'(np) * int'(pol_b_ff));
      cell_idx = CW'(int'(wrap_coord(cell_x_ff, X_SIZE)) * Y_SIZE
                     + int'(wrap_coord(cell_y_ff, Y_SIZE)));
      model_addr = MAW'(int'(cell_idx) * MODEL_SLOTS + int'(mslot));
      meas_addr  = QAW'(int'(cell_idx) * MEAS_SLOTS + int'(qslot));
   end

   always_comb begin
      status_in = pca_pkg::ST_OK;
      model_upd = 1'b0;
      meas_upd  = 1'b0;
      case (action_ff) inside
         pca_pkg::ACT_ADD_BOTH, pca_pkg::ACT_ADD_MODEL: begin
            if (!pol_ok) begin
               status_in = pca_pkg::ST_BAD_POL;
            end else if (pol_a_ff < pol_b_ff) begin
               status_in = pca_pkg::ST_ORDER;
            end else begin
               model_upd = 1'b1;
               meas_upd  = (action_ff == pca_pkg::ACT_ADD_BOTH);
            end
         end
         pca_pkg::ACT_ADD_MEAS: begin
            if (!pol_ok) begin
               status_in = pca_pkg::ST_BAD_POL;
            end else begin
               meas_upd = 1'b1;
            end
         end
         pca_pkg::ACT_READ: begin
            if (!pol_ok) begin
               status_in = pca_pkg::ST_BAD_POL;
            end
         end
         default: status_in = pca_pkg::ST_OK;
      endcase
   end

   always_comb begin
      r0_in = '0;
      r1_in = '0;
      r2_in = '0;
      r3_in = '0;
      if (action_ff == pca_pkg::ACT_READ && pol_ok) begin
         r0_in = model_rd[AW-1:0];
         r1_in = (pol_a_ff < pol_b_ff) ? pca_pkg::neg_sat(model_rd[2*AW-1:AW])
                                       : model_rd[2*AW-1:AW];
         r2_in = meas_rd[AW-1:0];
         r3_in = meas_rd[2*AW-1:AW];
      end
   end

   // clearing sweep walks the deeper store; the model store stops at its depth
   always_comb begin
      stat.out_free = !rsp_valid_ff || rsp_tready;
      stat.clr_last = (clr_cnt_ff == QAW'(MEAS_DEPTH - 1));
      clr_cnt_in    = clr_cnt_ff;
      if (cmd.clr_step) begin
         clr_cnt_in = stat.clr_last ? '0 : clr_cnt_ff + 1'b1;
      end
      clr_model = cmd.clr_step && (int'(clr_cnt_ff) < MODEL_DEPTH);
   end

   always_comb begin
      model_we    = clr_model || (cmd.commit && model_upd);
      meas_we     = cmd.clr_step || (cmd.commit && meas_upd);
      model_waddr = cmd.clr_step ? MAW'(clr_cnt_ff) : model_addr;
      meas_waddr  = cmd.clr_step ? clr_cnt_ff : meas_addr;
      model_wd    = cmd.clr_step ? '0
                  : {pca_pkg::sat_add(model_rd[2*AW-1:AW], model_im_ff),
                     pca_pkg::sat_add(model_rd[AW-1:0], model_re_ff)};
      meas_wd     = cmd.clr_step ? '0
                  : {pca_pkg::sat_add(meas_rd[2*AW-1:AW], meas_im_ff),
                     pca_pkg::sat_add(meas_rd[AW-1:0], meas_re_ff)};
   end

   pca_ram #(.WIDTH(2*AW), .DEPTH(MODEL_DEPTH)) u_model_ram (
      .clock   (clock),
      .wr_en   (model_we),
      .wr_addr (model_waddr),
      .wr_data (model_wd),
      .rd_en   (cmd.rd_en),
      .rd_addr (model_addr),
      .rd_data (model_rd)
   );

   pca_ram #(.WIDTH(2*AW), .DEPTH(MEAS_DEPTH)) u_meas_ram (
      .clock   (clock),
      .wr_en   (meas_we),
      .wr_addr (meas_waddr),
      .wr_data (meas_wd),
      .rd_en   (cmd.rd_en),
      .rd_addr (meas_addr),
      .rd_data (meas_rd)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         r0_ff     <= r0_in;
         r1_ff     <= r1_in;
         r2_ff     <= r2_in;
         r3_ff     <= r3_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, r3_ff, r2_ff, r1_ff, r0_ff, status_ff};

endmodule

// ===== rtl/pol_cross_product_accumulator_top.sv =====
// Top level of the polarization cross-product accumulator: controller plus datapath.
// Depends on pca_pkg, pca_ctrl, pca_datapath (and pca_ram below it).
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tuser: action; tdata: cell, pols, model/meas parts
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: status, four Q9.23 sums
//  csr     | in  | csr_wr_en             | csr_wr_data: npol
//
// Add, read and error items pass through accept, RAM read and write-back with result, as the
// read-modify-write goes through the registered read port of the accumulator RAMs.
// Clear walks X_SIZE*Y_SIZE*MAX_POL*MAX_POL addresses (4096 by default), then gives its result.
// After reset the same sweep runs once with req_tready low.
// A result waits in the output register; the next beat is accepted meanwhile and its
// write-back holds until that register is taken.
module pol_cross_product_accumulator_top #(
   parameter int MAX_POL = 4,
   parameter int X_SIZE  = 16,
   parameter int Y_SIZE  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // action
   input  logic [pca_pkg::ACT_W-1:0]         req_tuser,
   // cell_x, cell_y, pol_a, pol_b, model_re, model_im, meas_re, meas_im, zero pad
   input  logic [pca_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status, sum_model_re, sum_model_im, sum_meas_re, sum_meas_im, zero pad
   output logic [pca_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [pca_pkg::NPOL_W-1:0]        csr_wr_data
);
   pca_pkg::pca_cmd_type  cmd;
   pca_pkg::pca_stat_type stat;
   logic                  req_is_clear;

   assign req_is_clear = (req_tuser == pca_pkg::ACT_CLEAR);

   pca_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_is_clear (req_is_clear),
      .req_tready   (req_tready),
      .stat         (stat),
      .cmd          (cmd)
   );

   pca_datapath #(.MAX_POL(MAX_POL), .X_SIZE(X_SIZE), .Y_SIZE(Y_SIZE)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_step |-> !req_tready)
      else $error("beat accepted during clearing sweep");

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second beat accepted while an item is in flight");

   a_error_sums_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != pca_pkg::ST_OK) |-> (rsp_tdata[129:2] == '0))
      else $error("error result carries nonzero sums");

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten while held");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench of pol_cross_product_accumulator_top: drives request beats, mirrors
// both accumulator stores in a scoreboard class and checks every response beat against it.
// Depends on pca_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module tb_top;
   import pca_pkg::*;

   localparam int MAX_POL      = 4;
   localparam int X_SIZE       = 16;
   localparam int Y_SIZE       = 16;
   localparam int MODEL_SLOTS  = MAX_POL * (MAX_POL + 1) / 2;
   localparam int MEAS_SLOTS   = MAX_POL * MAX_POL;
   localparam int MODEL_DEPTH  = X_SIZE * Y_SIZE * MODEL_SLOTS;
   localparam int MEAS_DEPTH   = X_SIZE * Y_SIZE * MEAS_SLOTS;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int SAT_RAMP     = 400;

   localparam longint ACC_HI = 64'sd2147483647;
   localparam longint ACC_LO = -64'sd2147483648;

   localparam logic signed [IN_W-1:0] PART_MAX = 24'sh7FFFFF;
   localparam logic signed [IN_W-1:0] PART_MIN = 24'sh800000;

   typedef struct packed {
      logic [ACT_W-1:0]          action;
      logic [COORD_W-1:0]        cell_x;
      logic [COORD_W-1:0]        cell_y;
      logic [POL_W-1:0]          pol_a;
      logic [POL_W-1:0]          pol_b;
      logic signed [IN_W-1:0]    model_re;
      logic signed [IN_W-1:0]    model_im;
      logic signed [IN_W-1:0]    meas_re;
      logic signed [IN_W-1:0]    meas_im;
   } pca_req_type;

   typedef struct packed {
      logic [STAT_W-1:0]         status;
      logic signed [ACC_W-1:0]   sum_model_re;
      logic signed [ACC_W-1:0]   sum_model_im;
      logic signed [ACC_W-1:0]   sum_meas_re;
      logic signed [ACC_W-1:0]   sum_meas_im;
   } sum_result_type;

   class xprod_mirror;
      int                model_re[MODEL_DEPTH];
      int                model_im[MODEL_DEPTH];
      int                meas_re[MEAS_DEPTH];
      int                meas_im[MEAS_DEPTH];
      logic [NPOL_W-1:0] npol;
      sum_result_type    pending_sums[$];
      int                errors;
      int                n_requests;
      int                n_reads;
      int                n_clears;
      int                n_clamped;
      int                n_status[3];

      function new();
         npol       = NPOL_RST;
         errors     = 0;
         n_requests = 0;
         n_reads    = 0;
         n_clears   = 0;
         n_clamped  = 0;
         foreach (n_status[i]) n_status[i] = 0;
      endfunction

      function int clamp_acc(longint v);
         if (v > ACC_HI) begin
            n_clamped++;
            return int'(ACC_HI);
         end
         if (v < ACC_LO) begin
            n_clamped++;
            return int'(ACC_LO);
         end
         return int'(v);
      endfunction

      function void accept_request(pca_req_type r);
         int unsigned np, pa, pb, hi, lo, cell_no, mslot, mi, qi;
         sum_result_type e;
         np = (npol > MAX_POL) ? MAX_POL : npol;
         pa = r.pol_a;
         pb = r.pol_b;
         hi = (pa >= pb) ? pa : pb;
         lo = (pa >= pb) ? pb : pa;
         cell_no = r.cell_x * Y_SIZE + r.cell_y;
         mslot = (hi == lo) ? hi : np + lo + hi * (hi - 1) / 2;
         mi = (cell_no * MODEL_SLOTS + mslot) % MODEL_DEPTH;
         qi = (cell_no * MEAS_SLOTS + pa + np * pb) % MEAS_DEPTH;
         e = '0;
         n_requests++;
         if (r.action == ACT_CLEAR) begin
            foreach (model_re[i]) begin
               model_re[i] = 0;
               model_im[i] = 0;
            end
            foreach (meas_re[i]) begin
               meas_re[i] = 0;
               meas_im[i] = 0;
            end
            n_clears++;
         end else if (r.action <= ACT_READ) begin
            if (pa >= np || pb >= np) begin
               e.status = ST_BAD_POL;
            end else if ((r.action == ACT_ADD_BOTH || r.action == ACT_ADD_MODEL) && pa < pb) begin
               e.status = ST_ORDER;
            end else if (r.action == ACT_READ) begin
               e.sum_model_re = model_re[mi];
               e.sum_model_im = (pa < pb) ? clamp_acc(-longint'(model_im[mi])) : model_im[mi];
               e.sum_meas_re  = meas_re[qi];
               e.sum_meas_im  = meas_im[qi];
               n_reads++;
            end else begin
               if (r.action != ACT_ADD_MEAS) begin
                  model_re[mi] = clamp_acc(longint'(model_re[mi]) + r.model_re);
                  model_im[mi] = clamp_acc(longint'(model_im[mi]) + r.model_im);
               end
               if (r.action != ACT_ADD_MODEL) begin
                  meas_re[qi] = clamp_acc(longint'(meas_re[qi]) + r.meas_re);
                  meas_im[qi] = clamp_acc(longint'(meas_im[qi]) + r.meas_im);
               end
            end
         end
         n_status[e.status]++;
         pending_sums.push_back(e);
      endfunction

      function void compare(string name, logic signed [63:0] want, logic signed [63:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [RSP_TDATA_W-1:0] d);
         sum_result_type want;
         if (pending_sums.size() == 0) begin
            $error("response beat with no request outstanding");
            errors++;
            return;
         end
         want = pending_sums.pop_front();
         compare("status", want.status, d[1:0]);
         compare("sum_model_re", want.sum_model_re, $signed(d[33:2]));
         compare("sum_model_im", want.sum_model_im, $signed(d[65:34]));
         compare("sum_meas_re", want.sum_meas_re, $signed(d[97:66]));
         compare("sum_meas_im", want.sum_meas_im, $signed(d[129:98]));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ACT_W-1:0]       req_tuser = '0;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en = 1'b0;
   logic [NPOL_W-1:0]      csr_wr_data = '0;

   xprod_mirror mirror;
   bit          burst = 1'b0;
   bit          hold_rsp = 1'b0;

   pol_cross_product_accumulator_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [REQ_TDATA_W-1:0] pack_req(input pca_req_type r);
      return {4'b0, r.meas_im, r.meas_re, r.model_im, r.model_re,
              r.pol_b, r.pol_a, r.cell_y, r.cell_x};
   endfunction

   function automatic pca_req_type mk(input logic [ACT_W-1:0] act, input int cx, input int cy,
                                   input int pa, input int pb,
                                   input logic signed [IN_W-1:0] mre, input logic signed [IN_W-1:0] mim,
                                   input logic signed [IN_W-1:0] qre, input logic signed [IN_W-1:0] qim);
      pca_req_type r;
      r.action   = act;
      r.cell_x   = COORD_W'(cx);
      r.cell_y   = COORD_W'(cy);
      r.pol_a    = POL_W'(pa);
      r.pol_b    = POL_W'(pb);
      r.model_re = mre;
      r.model_im = mim;
      r.meas_re  = qre;
      r.meas_im  = qim;
      return r;
   endfunction

   function automatic logic signed [IN_W-1:0] rand_part();
      case ($urandom_range(0, 7))
         0:       return PART_MAX;
         1:       return PART_MIN;
         2:       return '0;
         3:       return '1;
         default: return IN_W'($urandom);
      endcase
   endfunction

   function automatic pca_req_type rand_req();
      pca_req_type r;
      int unsigned pick;
      bit          hot;
      pick = $urandom_range(0, 299);
      hot  = ($urandom_range(0, 3) != 0);
      if (pick == 0)
         r.action = ACT_CLEAR;
      else if (pick < 10)
         r.action = ACT_W'(ACT_CLEAR + 1 + $urandom_range(0, 2));
      else if (pick < 100)
         r.action = ACT_ADD_BOTH;
      else if (pick < 145)
         r.action = ACT_ADD_MODEL;
      else if (pick < 190)
         r.action = ACT_ADD_MEAS;
      else
         r.action = ACT_READ;
      r.cell_x   = COORD_W'(hot ? $urandom_range(0, 1) : $urandom_range(0, 15));
      r.cell_y   = COORD_W'(hot ? $urandom_range(0, 1) : $urandom_range(0, 15));
      r.pol_a    = POL_W'($urandom_range(0, 3));
      r.pol_b    = POL_W'($urandom_range(0, 3));
      r.model_re = rand_part();
      r.model_im = rand_part();
      r.meas_re  = rand_part();
      r.meas_im  = rand_part();
      return r;
   endfunction

   // one cell, cross hand (1,0): drive the accumulators into both rails
   function automatic pca_req_type sat_req(input bit ramp);
      pca_req_type r;
      r = rand_req();
      r.cell_x = 4'd9;
      r.cell_y = 4'd6;
      if ($urandom_range(0, 4) == 0) begin
         r.action = ACT_READ;
         r.pol_a  = $urandom_range(0, 1) ? 2'd1 : 2'd0;
         r.pol_b  = (r.pol_a == 2'd1) ? 2'd0 : 2'd1;
      end else begin
         r.action = ACT_ADD_BOTH;
         r.pol_a  = 2'd1;
         r.pol_b  = 2'd0;
         if (ramp || $urandom_range(0, 1) == 0) begin
            r.model_re = PART_MAX;
            r.model_im = PART_MIN;
            r.meas_re  = PART_MIN;
            r.meas_im  = PART_MAX;
         end else begin
            r.model_re = PART_MIN;
            r.model_im = PART_MAX;
            r.meas_re  = PART_MAX;
            r.meas_im  = PART_MIN;
         end
      end
      return r;
   endfunction

   task automatic send_item(input pca_req_type r);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.action;
      req_tdata  <= pack_req(r);
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      mirror.accept_request(r);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (mirror.pending_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_npol(input int v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= NPOL_W'(v);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      mirror.npol = NPOL_W'(v);
   endtask

   task automatic run_phase(input int npol_val, input bit start_clear, input int n,
                            input bit sat_mode, input bit squeeze);
      pca_req_type r;
      int          i;
      drain_results();
      write_npol(npol_val);
      if (start_clear) begin
         r = rand_req();
         r.action = ACT_CLEAR;
         send_item(r);
      end
      if (squeeze) hold_rsp = 1'b1;
      for (i = 0; i < n; i++) begin
         if (i % 64 == 0) burst = squeeze && i == 0 ? 1'b1 : ($urandom_range(0, 3) == 0);
         r = sat_mode ? sat_req(i < SAT_RAMP) : rand_req();
         send_item(r);
      end
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            stall = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end else begin
            stall = burst ? 0 : $urandom_range(0, 9);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         mirror.check_result(rsp_tdata);
      end
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      mirror = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);

      // directed beats at reset npol
      send_item(mk(ACT_ADD_BOTH, 3, 2, 2, 1, PART_MAX, PART_MAX, PART_MIN, PART_MIN));
      send_item(mk(ACT_ADD_BOTH, 3, 2, 2, 1, PART_MAX, PART_MIN, PART_MAX, 24'sd1));
      send_item(mk(ACT_ADD_MODEL, 3, 2, 2, 1, -24'sd1, 24'sh123456, 0, 0));
      send_item(mk(ACT_ADD_MEAS, 3, 2, 1, 2, 24'sh0F0F0F, PART_MIN, PART_MAX, 24'sh555555));
      send_item(mk(ACT_READ, 3, 2, 2, 1, 0, 0, 0, 0));
      send_item(mk(ACT_READ, 3, 2, 1, 2, 0, 0, 0, 0));
      send_item(mk(ACT_ADD_BOTH, 0, 0, 0, 3, PART_MAX, PART_MAX, PART_MAX, PART_MAX));
      send_item(mk(ACT_ADD_MODEL, 0, 0, 1, 3, PART_MIN, PART_MIN, 0, 0));
      send_item(mk(ACT_ADD_MEAS, 15, 15, 0, 3, 0, 0, PART_MAX, PART_MIN));
      send_item(mk(ACT_READ, 15, 15, 0, 3, 0, 0, 0, 0));
      send_item(mk(ACT_READ, 15, 15, 3, 0, 0, 0, 0, 0));
      send_item(mk(ACT_ADD_BOTH, 15, 15, 3, 3, PART_MIN, PART_MIN, PART_MIN, PART_MIN));
      send_item(mk(ACT_READ, 15, 15, 3, 3, '1, '1, '1, '1));
      send_item(mk(ACT_W'(ACT_CLEAR + 1), 3, 2, 2, 1, PART_MAX, PART_MAX, PART_MAX, PART_MAX));
      send_item(mk(ACT_W'(ACT_CLEAR + 2), 0, 0, 0, 0, PART_MIN, PART_MIN, PART_MIN, PART_MIN));
      send_item(mk(ACT_W'(ACT_CLEAR + 3), 15, 15, 3, 3, '1, '1, '1, '1));
      send_item(mk(ACT_CLEAR, 15, 15, 3, 3, PART_MAX, PART_MIN, '1, PART_MAX));
      send_item(mk(ACT_READ, 3, 2, 2, 1, 0, 0, 0, 0));

      // npol change without a clear, out-of-range polarizations
      drain_results();
      write_npol(2);
      send_item(mk(ACT_ADD_BOTH, 1, 1, 3, 0, PART_MAX, PART_MAX, PART_MAX, PART_MAX));
      send_item(mk(ACT_ADD_MODEL, 3, 2, 1, 0, 24'sd77, -24'sd5, 0, 0));
      send_item(mk(ACT_READ, 3, 2, 0, 1, 0, 0, 0, 0));
      send_item(mk(ACT_READ, 1, 1, 2, 2, 0, 0, 0, 0));

      run_phase(4, 1'b1, 180, 1'b0, 1'b0);
      run_phase(1, 1'b1, 150, 1'b0, 1'b0);
      run_phase(2, 1'b1, 500, 1'b1, 1'b0);
      run_phase(3, 1'b0, 150, 1'b0, 1'b0);
      run_phase(0, 1'b0, 80, 1'b0, 1'b0);
      run_phase(7, 1'b1, 200, 1'b0, 1'b1);
      run_phase(5, 1'b0, 150, 1'b0, 1'b0);
      run_phase(6, 1'b1, 170, 1'b0, 1'b0);
      run_phase(4, 1'b0, 300, 1'b0, 1'b0);
      drain_results();

      $display("run covered %0d request beats over npol 0..7: %0d reads, %0d clears, %0d clamps",
               mirror.n_requests, mirror.n_reads, mirror.n_clears, mirror.n_clamped);
      $display("responses: %0d ok, %0d bad polarization, %0d order rejects",
               mirror.n_status[ST_OK], mirror.n_status[ST_BAD_POL], mirror.n_status[ST_ORDER]);
      if (mirror.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== pol_cross_product_accumulator_top.f =====
rtl/pca_pkg.sv
rtl/pca_ram.sv
rtl/pca_ctrl.sv
rtl/pca_datapath.sv
rtl/pol_cross_product_accumulator_top.sv
verif/tb_top.sv
